// ----- hw/rtl/u8lcd_pkg.sv -----
// Shared constants and types of the UTF-8 LCD glyph cache.
package u8lcd_pkg;

	// Glyph library and custom character slots
	localparam int LIB_DEPTH   = 64;
	localparam int LIB_AW      = $clog2(LIB_DEPTH);
	localparam int CNT_W       = LIB_AW + 1;
	localparam int GLYPH_CNT_W = 7;
	localparam int SLOT_COUNT  = 8;
	localparam int SLOT_W      = 3;
	localparam int CODE_W      = 16;

	// Input commands (tuser)
	localparam logic [1:0] CMD_TEXT   = 2'd0;
	localparam logic [1:0] CMD_START  = 2'd1;
	localparam logic [1:0] CMD_LIB_WR = 2'd2;

	// Result kinds (tuser)
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_LOAD  = 1'b1;

	localparam logic [7:0] CHAR_SPACE = 8'h20;

	// Library search status
	typedef struct packed {
		logic              done;
		logic              found;
		logic [LIB_AW-1:0] index;
	} lib_status_t;

endpackage

// ----- hw/rtl/u8lcd_lib.sv -----
// Glyph code library memory with a linear search engine.
module u8lcd_lib
	import u8lcd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic [LIB_AW-1:0] wr_idx,
	input  logic [CODE_W-1:0] wr_code,
	input  logic              start,
	input  logic [CODE_W-1:0] key,
	input  logic [CNT_W-1:0]  limit,
	output lib_status_t       status
);

	logic [CODE_W-1:0] mem_q [LIB_DEPTH];
	logic [CODE_W-1:0] rd_data_s1;
	logic [LIB_AW-1:0] rd_idx_s1;
	logic              rd_vld_s1;
	logic              busy_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  limit_q;
	logic [CODE_W-1:0] key_q;
	logic              issue;
	logic              hit;
	logic              at_end;
	logic              done;

	// Memory: one write port, one registered read port walking the entries
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_idx] <= wr_code;
		end
		rd_data_s1 <= mem_q[cnt_q[LIB_AW-1:0]];
		rd_idx_s1  <= cnt_q[LIB_AW-1:0];
	end

	always_ff @(posedge clk) begin
		if (start) begin
			key_q   <= key;
			limit_q <= limit;
		end
	end

	assign hit    = rd_vld_s1 && (rd_data_s1 == key_q);
	assign at_end = rd_vld_s1 && ({1'b0, rd_idx_s1} == (limit_q - CNT_W'(1)));
	assign done   = busy_q && (hit || at_end);
	assign issue  = busy_q && !done && (cnt_q < limit_q);

	// Search control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else if (start) begin
			busy_q    <= 1'b1;
			cnt_q     <= '0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= issue;
			if (issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (done) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign status.done  = done;
	assign status.found = hit;
	assign status.index = rd_idx_s1;

endmodule

// ----- hw/rtl/utf8_lcd_glyph_cache.sv -----
// UTF-8 byte stream decoder with a FIFO-replaced custom glyph cache for a character LCD.
// An ASCII character or slot hit goes from acceptance to the emit state, then to the output
// register; the next request is taken when the emit state hands it on, which waits while
// the output is held. A miss walks the library one entry per cycle, then a found glyph
// issues a load through the load state before its write. Other requests leave it idle.
// Reset clears control state and slot valid bits; library contents stay undefined until written.
module utf8_lcd_glyph_cache
	import u8lcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data,       // glyph_count
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // byte_in, max_chars, entry_index, entry_code, pad
	input  logic [1:0]  s_axis_tuser,   // cmd
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // char_code, slot, glyph_index, pad
	output logic [0:0]  m_axis_tuser,   // op
	output logic        m_axis_tlast
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_SEARCH = 4'b0010,
		ST_LOAD   = 4'b0100,
		ST_EMIT   = 4'b1000
	} state_t;

	state_t            state_q;
	logic [GLYPH_CNT_W-1:0] glyph_count_q;
	logic [CODE_W-1:0] partial_q;
	logic [1:0]        pending_q;
	logic [7:0]        chars_left_q;
	logic              stopped_q;
	logic [SLOT_W-1:0] slot_ptr_q;
	logic [SLOT_COUNT-1:0] slot_vld_q;
	logic [CODE_W-1:0] slot_tag_q [SLOT_COUNT];
	logic [CODE_W-1:0] key_q;
	logic [7:0]        char_q;
	logic [LIB_AW-1:0] gidx_q;

	logic              m_valid_q;
	logic              m_op_q;
	logic              m_last_q;
	logic [7:0]        m_char_q;
	logic [SLOT_W-1:0] m_slot_q;
	logic [LIB_AW-1:0] m_gidx_q;

	logic [7:0]        in_byte;
	logic [7:0]        in_max;
	logic [1:0]        in_cmd;
	logic              s_fire;
	logic              out_free;
	logic [CODE_W-1:0] nxt_partial;
	logic [1:0]        nxt_pending;
	logic [CODE_W-1:0] dec_code;
	logic              dec_emit;
	logic              dec_stop;
	logic              hit;
	logic [SLOT_W-1:0] hit_idx;
	logic [CNT_W-1:0]  limit;
	logic              text_ok;
	logic              search_start;
	logic [7:0]        chars_dec;
	lib_status_t       lib_st;

	assign in_byte  = s_axis_tdata[7:0];
	assign in_max   = s_axis_tdata[15:8];
	assign in_cmd   = s_axis_tuser;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign s_fire   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_valid_q || m_axis_tready;
	assign cfg_ready = 1'b1;

	// Config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			glyph_count_q <= '0;
		end else if (cfg_valid) begin
			glyph_count_q <= cfg_data;
		end
	end

	assign limit = (glyph_count_q > GLYPH_CNT_W'(LIB_DEPTH)) ? CNT_W'(LIB_DEPTH)
		: CNT_W'(glyph_count_q);

	// UTF-8 byte decode
	always_comb begin
		nxt_partial = partial_q;
		nxt_pending = pending_q;
		dec_code    = '0;
		dec_emit    = 1'b0;
		dec_stop    = 1'b0;
		if (pending_q != 2'd0) begin
			nxt_partial = {partial_q[CODE_W-7:0], in_byte[5:0]};
			nxt_pending = pending_q - 2'd1;
			if (nxt_pending == 2'd0) begin
				dec_emit = 1'b1;
				dec_code = nxt_partial;
			end
		end else if (in_byte == 8'h00) begin
			dec_stop = 1'b1;
		end else if (in_byte < 8'h80) begin
			dec_emit = 1'b1;
			dec_code = {8'h00, in_byte};
		end else if ((in_byte & 8'hE0) == 8'hC0) begin
			nxt_partial = {11'd0, in_byte[4:0]};
			nxt_pending = 2'd1;
		end else if ((in_byte & 8'hF0) == 8'hE0) begin
			nxt_partial = {12'd0, in_byte[3:0]};
			nxt_pending = 2'd2;
		end
	end

	// Slot tag compare, lowest matching slot wins
	always_comb begin
		hit     = 1'b0;
		hit_idx = '0;
		for (int s = SLOT_COUNT - 1; s >= 0; s--) begin
			if (slot_vld_q[s] && (slot_tag_q[s] == dec_code)) begin
				hit     = 1'b1;
				hit_idx = SLOT_W'(s);
			end
		end
	end

	assign text_ok      = s_fire && (in_cmd == CMD_TEXT) && !stopped_q;
	assign search_start = text_ok && dec_emit && (dec_code >= CODE_W'(128)) && !hit
		&& (limit != '0);
	assign chars_dec    = (chars_left_q != 8'd0) ? chars_left_q - 8'd1 : 8'd0;

	u8lcd_lib u_lib (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (s_fire && (in_cmd == CMD_LIB_WR)),
		.wr_idx  (s_axis_tdata[21:16]),
		.wr_code (s_axis_tdata[37:22]),
		.start   (search_start),
		.key     (dec_code),
		.limit   (limit),
		.status  (lib_st)
	);

	// Control state machine
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			partial_q    <= '0;
			pending_q    <= '0;
			chars_left_q <= '0;
			stopped_q    <= 1'b1;
			slot_ptr_q   <= '0;
			slot_vld_q   <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_fire && (in_cmd == CMD_START)) begin
						chars_left_q <= in_max;
						stopped_q    <= (in_max == 8'd0);
						partial_q    <= '0;
						pending_q    <= '0;
					end else if (text_ok) begin
						partial_q <= nxt_partial;
						pending_q <= nxt_pending;
						if (dec_stop || (dec_emit && (dec_code == '0))) begin
							stopped_q <= 1'b1;
						end else if (dec_emit) begin
							if (search_start) begin
								state_q <= ST_SEARCH;
							end else begin
								state_q <= ST_EMIT;
							end
						end
					end
				end
				ST_SEARCH: begin
					if (lib_st.done) begin
						state_q <= lib_st.found ? ST_LOAD : ST_EMIT;
					end
				end
				ST_LOAD: begin
					if (out_free) begin
						slot_vld_q[slot_ptr_q] <= 1'b1;
						slot_ptr_q <= slot_ptr_q + SLOT_W'(1);
						state_q    <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						chars_left_q <= chars_dec;
						if (chars_dec == 8'd0) begin
							stopped_q <= 1'b1;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working payload: search key, character to write, slot tags
	always_ff @(posedge clk) begin
		if (text_ok && dec_emit) begin
			key_q <= dec_code;
			if (dec_code < CODE_W'(128)) begin
				char_q <= dec_code[7:0];
			end else if (hit) begin
				char_q <= {{(8 - SLOT_W){1'b0}}, hit_idx};
			end else begin
				char_q <= CHAR_SPACE;
			end
		end
		if ((state_q == ST_SEARCH) && lib_st.done) begin
			gidx_q <= lib_st.index;
			char_q <= CHAR_SPACE;
		end
		if ((state_q == ST_LOAD) && out_free) begin
			slot_tag_q[slot_ptr_q] <= key_q;
			char_q <= {{(8 - SLOT_W){1'b0}}, slot_ptr_q};
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_free) begin
			m_valid_q <= (state_q == ST_LOAD) || (state_q == ST_EMIT);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (state_q == ST_LOAD) begin
				m_op_q   <= OP_LOAD;
				m_last_q <= 1'b0;
				m_char_q <= 8'd0;
				m_slot_q <= slot_ptr_q;
				m_gidx_q <= gidx_q;
			end else begin
				m_op_q   <= OP_WRITE;
				m_last_q <= 1'b1;
				m_char_q <= char_q;
				m_slot_q <= '0;
				m_gidx_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {7'd0, m_gidx_q, m_slot_q, m_char_q};
	assign m_axis_tuser  = m_op_q;
	assign m_axis_tlast  = m_last_q;

	// A load request is never the final one of its character
	a_load_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && (m_axis_tuser == OP_LOAD)) |-> !m_axis_tlast)
		else $error("load request marked last");

	// The slot pointer advances exactly when a load leaves
	a_ptr_step: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_LOAD) && out_free) |=> (slot_ptr_q == $past(slot_ptr_q) + SLOT_W'(1)))
		else $error("slot pointer did not advance on load");

	// The library search only finishes while the controller waits for it
	a_search_done: assert property (@(posedge clk) disable iff (!arst_n)
		lib_st.done |-> (state_q == ST_SEARCH))
		else $error("library search finished outside search state");

endmodule

// ----- verif/tb_utf8_lcd_glyph_cache.sv -----
// Self-checking testbench of the UTF-8 LCD glyph cache: directed table, then random streams.
module tb_utf8_lcd_glyph_cache;
	import u8lcd_pkg::*;

	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int IDLE_WAIT = 100;        // longer than the worst library walk
	localparam int LONG_HOLD = 1500;       // receiver hold-off that backs up the block
	localparam int PHASE_ITEMS = 250;
	localparam int unsigned CYCLE_LIMIT = 2_000_000;

	// One LCD command as it leaves the block
	typedef struct packed {
		logic       op;
		logic [7:0] char_code;
		logic [2:0] slot;
		logic [5:0] glyph_index;
		logic       last;
	} lcd_result_t;

	// One row of the directed table
	typedef struct packed {
		logic [1:0]  cmd;
		logic [7:0]  byte_in;
		logic [7:0]  max_chars;
		logic [5:0]  entry_index;
		logic [15:0] entry_code;
		logic        typed;
		logic        typed_n;
		logic [7:0]  typed_char;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [6:0]  cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [23:0] m_axis_tdata;
	logic [0:0]  m_axis_tuser;
	logic        m_axis_tlast;

	// Cache model state
	logic [15:0] slot_code [SLOT_COUNT];
	logic        slot_live [SLOT_COUNT];
	logic [2:0]  fill_ptr;
	logic [15:0] glyph_lib [LIB_DEPTH];
	logic [15:0] seq_code;
	logic [1:0]  seq_left;
	logic [7:0]  char_budget;
	logic        halted;
	logic [6:0]  glyph_limit;

	lcd_result_t step_res [2];
	int          step_n;
	lcd_result_t lcd_expected [$];
	dir_row_t    dir_rows [$];

	int          fail_count = 0;
	int          items_sent = 0;
	int unsigned cycle_count = 0;
	bit          quiet = 1'b0;
	bit          hold_long_req = 1'b0;

	utf8_lcd_glyph_cache dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run guard
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("tb_utf8_lcd_glyph_cache failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (fail_count < 40)
			$display("MISMATCH %s: got 0x%0h want 0x%0h (cycle %0d)", what, got, want,
				cycle_count);
		fail_count++;
	endtask

	// Mostly short gaps, a few long ones, none in quiet phases
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [39:0] pack_req(input logic [7:0] b, input logic [7:0] m,
		input logic [5:0] ix, input logic [15:0] code);
		return {2'b00, code, ix, m, b};
	endfunction

	function automatic dir_row_t mk_row(input logic [1:0] cmd, input logic [7:0] b,
		input logic [7:0] m, input logic [5:0] ix, input logic [15:0] code,
		input logic typed, input logic n, input logic [7:0] ch);
		return '{cmd, b, m, ix, code, typed, n, ch};
	endfunction

	function automatic void add_write(input logic [7:0] ch);
		step_res[step_n] = '{OP_WRITE, ch, 3'd0, 6'd0, 1'b1};
		step_n++;
	endfunction

	function automatic void count_char();
		if (char_budget != 8'd0)
			char_budget--;
		if (char_budget == 8'd0)
			halted = 1'b1;
	endfunction

	// Write one decoded character: ASCII, slot hit, library load or space; code 0 halts
	function automatic void emit_char(input logic [15:0] code);
		int lim;
		bit hit;
		hit = 1'b0;
		if (code == 16'd0) begin
			halted = 1'b1;
			return;
		end
		if (code < 16'd128) begin
			add_write(code[7:0]);
			count_char();
			return;
		end
		for (int s = 0; s < SLOT_COUNT; s++) begin
			if (!hit && slot_live[s] && slot_code[s] == code) begin
				add_write(8'(s));
				hit = 1'b1;
			end
		end
		lim = (int'(glyph_limit) > LIB_DEPTH) ? LIB_DEPTH : int'(glyph_limit);
		for (int i = 0; i < lim; i++) begin
			if (!hit && glyph_lib[i] == code) begin
				step_res[step_n] = '{OP_LOAD, 8'd0, fill_ptr, 6'(i), 1'b0};
				step_n++;
				slot_code[fill_ptr] = code;
				slot_live[fill_ptr] = 1'b1;
				add_write({5'd0, fill_ptr});
				fill_ptr = fill_ptr + 3'd1;
				hit = 1'b1;
			end
		end
		if (!hit)
			add_write(CHAR_SPACE);
		count_char();
	endfunction

	// Advance the model by one request, results go to step_res
	function automatic void decode_request(input logic [1:0] cmd, input logic [39:0] data);
		logic [7:0] b;
		b = data[7:0];
		step_n = 0;
		case (cmd)
			CMD_START: begin
				char_budget = data[15:8];
				halted = (data[15:8] == 8'd0);
				seq_code = 16'd0;
				seq_left = 2'd0;
			end
			CMD_LIB_WR: glyph_lib[data[21:16]] = data[37:22];
			CMD_TEXT: begin
				if (!halted) begin
					if (seq_left != 2'd0) begin
						seq_code = {seq_code[9:0], b[5:0]};
						seq_left--;
						if (seq_left == 2'd0)
							emit_char(seq_code);
					end else if (b == 8'd0) begin
						halted = 1'b1;
					end else if (b < 8'h80) begin
						emit_char({8'd0, b});
					end else if (b[7:5] == 3'b110) begin
						seq_code = {11'd0, b[4:0]};
						seq_left = 2'd1;
					end else if (b[7:4] == 4'b1110) begin
						seq_code = {12'd0, b[3:0]};
						seq_left = 2'd2;
					end
				end
			end
			default: ;
		endcase
	endfunction

	// Offer one request, wait for acceptance, then book its results
	task automatic send_req(input logic [1:0] cmd, input logic [39:0] data,
		input bit typed = 1'b0, input bit t_n = 1'b0, input logic [7:0] t_char = 8'd0);
		int gap;
		gap = pick_idle();
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= data;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		decode_request(cmd, data);
		if (typed) begin
			if (t_n)
				lcd_expected.push_back('{OP_WRITE, t_char, 3'd0, 6'd0, 1'b1});
		end else begin
			for (int k = 0; k < step_n; k++)
				lcd_expected.push_back(step_res[k]);
		end
		items_sent++;
		@(negedge clk);
	endtask

	task automatic send_text(input logic [7:0] b);
		send_req(CMD_TEXT, pack_req(b, 8'($urandom), 6'($urandom), 16'($urandom)));
	endtask

	task automatic send_start(input logic [7:0] m);
		send_req(CMD_START, pack_req(8'($urandom), m, 6'($urandom), 16'($urandom)));
	endtask

	// Encode a code point as a two- or three-byte sequence
	task automatic send_code(input logic [15:0] code, input bit two_byte);
		if (two_byte) begin
			send_text({3'b110, code[10:6]});
			send_text({2'b10, code[5:0]});
		end else begin
			send_text({4'b1110, code[15:12]});
			send_text({2'b10, code[11:6]});
			send_text({2'b10, code[5:0]});
		end
	endtask

	// Stop offering and wait until the block has settled
	task automatic drain_block();
		s_axis_tvalid <= 1'b0;
		while (lcd_expected.size() != 0)
			@(negedge clk);
		repeat (IDLE_WAIT) @(negedge clk);
	endtask

	task automatic write_glyph_count(input logic [6:0] v);
		drain_block();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		glyph_limit = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] pick_limit();
		int r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return 8'($urandom_range(1, 24));
		if (r == 7)
			return 8'd0;
		if (r == 8)
			return 8'hFF;
		return 8'($urandom);
	endfunction

	// Random traffic: mostly well-formed strings, some noise and broken sequences
	task automatic random_event();
		int r;
		int ix;
		logic [15:0] code;
		if (halted && $urandom_range(0, 9) != 0)
			send_start(pick_limit());
		r = $urandom_range(0, 99);
		if (r < 5) begin
			send_start(pick_limit());
		end else if (r < 35) begin
			send_text(8'($urandom_range(1, 127)));
		end else if (r < 62) begin
			// small working set so that slots hit and get evicted
			ix = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 11) : $urandom_range(0, 63);
			code = glyph_lib[ix];
			send_code(code, code < 16'h800 && $urandom_range(0, 1) == 1);
		end else if (r < 70) begin
			send_code(16'($urandom), $urandom_range(0, 3) == 0);
		end else if (r < 74) begin
			send_text(8'h00);
		end else if (r < 79) begin
			if ($urandom_range(0, 1) == 1)
				send_text(8'($urandom_range(8'h80, 8'hBF)));
			else
				send_text(8'($urandom_range(8'hF0, 8'hFF)));
		end else if (r < 84) begin
			send_req(CMD_LIB_WR, pack_req(8'($urandom), 8'($urandom), 6'($urandom),
				16'($urandom_range(16'h80, 16'hFFFF))));
		end else if (r < 87) begin
			send_req(CMD_UNUSED, pack_req(8'($urandom), 8'($urandom), 6'($urandom),
				16'($urandom)));
		end else if (r < 93) begin
			// lead byte whose sequence is cut short
			send_text(8'($urandom_range(8'hC0, 8'hEF)));
		end else begin
			send_text(8'($urandom));
		end
	endtask

	// Result checker
	always @(posedge clk) begin
		lcd_result_t got;
		lcd_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got = '{m_axis_tuser[0], m_axis_tdata[7:0], m_axis_tdata[10:8],
				m_axis_tdata[16:11], m_axis_tlast};
			if (lcd_expected.size() == 0) begin
				report_mismatch("result with nothing expected", int'(got), 0);
			end else begin
				want = lcd_expected.pop_front();
				if (got.op != want.op)
					report_mismatch("op", got.op, want.op);
				if (got.char_code != want.char_code)
					report_mismatch("char_code", got.char_code, want.char_code);
				if (got.slot != want.slot)
					report_mismatch("slot", got.slot, want.slot);
				if (got.glyph_index != want.glyph_index)
					report_mismatch("glyph_index", got.glyph_index, want.glyph_index);
				if (got.last != want.last)
					report_mismatch("last", got.last, want.last);
			end
		end
	end

	// Result receiver with random stalls and one long hold-off
	initial begin
		int n;
		m_axis_tready = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_long_req) begin
				hold_long_req = 1'b0;
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD) @(negedge clk);
			end else begin
				n = pick_idle();
				if (n > 0) begin
					m_axis_tready <= 1'b0;
					repeat (n) @(negedge clk);
				end
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Stimulus
	initial begin
		int phase_gc [6];
		int gc;
		int target;
		bit hold_done;
		logic [15:0] code;
		phase_gc = '{64, 127, 1, 9, -1, 64};
		hold_done = 1'b0;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = 7'd0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 40'd0;
		s_axis_tuser = CMD_TEXT;
		for (int s = 0; s < SLOT_COUNT; s++) begin
			slot_code[s] = 16'hFFFF;
			slot_live[s] = 1'b0;
		end
		fill_ptr = 3'd0;
		seq_code = 16'd0;
		seq_left = 2'd0;
		char_budget = 8'd0;
		halted = 1'b1;
		glyph_limit = 7'd0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty library, so every non-ASCII code writes a space
		write_glyph_count(7'd0);
		dir_rows.push_back(mk_row(CMD_TEXT,   8'h41, 8'd0,   6'd0,  16'h0000, 1, 0, 8'h00));
		dir_rows.push_back(mk_row(CMD_UNUSED, 8'h41, 8'd5,   6'd0,  16'h0000, 1, 0, 8'h00));
		dir_rows.push_back(mk_row(CMD_START,  8'h00, 8'd0,   6'd0,  16'h0000, 1, 0, 8'h00));
		dir_rows.push_back(mk_row(CMD_TEXT,   8'h41, 8'd0,   6'd0,  16'h0000, 1, 0, 8'h00));
		dir_rows.push_back(mk_row(CMD_START,  8'h00, 8'hFF,  6'd0,  16'h0000, 1, 0, 8'h00));
		dir_rows.push_back(mk_row(CMD_TEXT,   8'h41, 8'd0,   6'd0,  16'h0000, 1, 1, 8'h41));
		dir_rows.push_back(mk_row(CMD_TEXT,   8'h7F, 8'd0,   6'd0,  16'h0000, 1, 1, 8'h7F));
		dir_rows.push_back(mk_row(CMD_TEXT,   8'h80, 8'd0,   6'd0,  16'h0000, 1, 0, 8'h00));
		dir_rows.push_back(mk_row(CMD_TEXT,   8'hFF, 8'd0,   6'd0,  16'h0000, 1, 0, 8'h00));
		dir_rows.push_back(mk_row(CMD_TEXT,   8'hC3, 8'd0,   6'd0,  16'h0000, 1, 0, 8'h00));
		dir_rows.push_back(mk_row(CMD_TEXT,   8'hA9, 8'd0,   6'd0,  16'h0000, 1, 1, CHAR_SPACE));
		// 0xFFFF must not hit the reset tags, which are not valid
		dir_rows.push_back(mk_row(CMD_TEXT,   8'hEF, 8'd0,   6'd0,  16'h0000, 1, 0, 8'h00));
		dir_rows.push_back(mk_row(CMD_TEXT,   8'hBF, 8'd0,   6'd0,  16'h0000, 1, 0, 8'h00));
		dir_rows.push_back(mk_row(CMD_TEXT,   8'hBF, 8'd0,   6'd0,  16'h0000, 1, 1, CHAR_SPACE));
		// overlong two-byte 'A' is written as ASCII
		dir_rows.push_back(mk_row(CMD_TEXT,   8'hC1, 8'd0,   6'd0,  16'h0000, 1, 0, 8'h00));
		dir_rows.push_back(mk_row(CMD_TEXT,   8'h81, 8'd0,   6'd0,  16'h0000, 1, 1, 8'h41));
		// zero continuation bytes decode to code 0, which ends the string
		dir_rows.push_back(mk_row(CMD_TEXT,   8'hE0, 8'd0,   6'd0,  16'h0000, 1, 0, 8'h00));
		dir_rows.push_back(mk_row(CMD_TEXT,   8'h00, 8'd0,   6'd0,  16'h0000, 1, 0, 8'h00));
		dir_rows.push_back(mk_row(CMD_TEXT,   8'h00, 8'd0,   6'd0,  16'h0000, 1, 0, 8'h00));
		// restart drops a partial sequence; limit of two ends the string
		dir_rows.push_back(mk_row(CMD_START,  8'h00, 8'd2,   6'd0,  16'h0000, 1, 0, 8'h00));
		dir_rows.push_back(mk_row(CMD_TEXT,   8'hC5, 8'd0,   6'd0,  16'h0000, 1, 0, 8'h00));
		dir_rows.push_back(mk_row(CMD_START,  8'h00, 8'd2,   6'd0,  16'h0000, 1, 0, 8'h00));
		dir_rows.push_back(mk_row(CMD_TEXT,   8'h42, 8'd0,   6'd0,  16'h0000, 1, 1, 8'h42));
		dir_rows.push_back(mk_row(CMD_TEXT,   8'h43, 8'd0,   6'd0,  16'h0000, 1, 1, 8'h43));
		dir_rows.push_back(mk_row(CMD_TEXT,   8'h44, 8'd0,   6'd0,  16'h0000, 1, 0, 8'h00));
		dir_rows.push_back(mk_row(CMD_START,  8'h00, 8'd3,   6'd0,  16'h0000, 1, 0, 8'h00));
		dir_rows.push_back(mk_row(CMD_TEXT,   8'h00, 8'd0,   6'd0,  16'h0000, 1, 0, 8'h00));
		dir_rows.push_back(mk_row(CMD_LIB_WR, 8'h00, 8'd0,   6'd63, 16'hFFFF, 0, 0, 8'h00));
		dir_rows.push_back(mk_row(CMD_LIB_WR, 8'h00, 8'd0,   6'd0,  16'h0080, 0, 0, 8'h00));
		foreach (dir_rows[k])
			send_req(dir_rows[k].cmd, pack_req(dir_rows[k].byte_in, dir_rows[k].max_chars,
				dir_rows[k].entry_index, dir_rows[k].entry_code), dir_rows[k].typed,
				dir_rows[k].typed_n, dir_rows[k].typed_char);

		// Fill the whole library before any search can reach it
		for (int i = 0; i < LIB_DEPTH; i++) begin
			if (i == 2)
				code = 16'hFFFF;
			else if (i == 7)
				code = 16'($urandom_range(0, 127));
			else if (i == 40)
				code = glyph_lib[3];
			else if (i % 8 == 5)
				code = 16'($urandom_range(16'h80, 16'h7FF));
			else
				code = 16'($urandom_range(16'h80, 16'hFFFF));
			send_req(CMD_LIB_WR, pack_req(8'($urandom), 8'($urandom), 6'(i), code));
		end

		// Random phases, each under its own glyph count
		for (int p = 0; p < 6; p++) begin
			gc = (phase_gc[p] < 0) ? $urandom_range(0, 127) : phase_gc[p];
			write_glyph_count(7'(gc));
			quiet = (p == 3);
			target = items_sent + PHASE_ITEMS;
			while (items_sent < target) begin
				if (p == 1 && !hold_done && items_sent > target - 150) begin
					hold_long_req = 1'b1;
					hold_done = 1'b1;
				end
				random_event();
			end
		end

		drain_block();
		if (fail_count == 0)
			$display("tb_utf8_lcd_glyph_cache passed");
		else
			$display("tb_utf8_lcd_glyph_cache failed");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/u8lcd_pkg.sv
hw/rtl/u8lcd_lib.sv
hw/rtl/utf8_lcd_glyph_cache.sv
verif/tb_utf8_lcd_glyph_cache.sv
